/* rtl/mwo_pkg.sv */
// Shared types, constants and tables for the mecanum wheel odometry block.
// No dependencies; used by every file in rtl.
package mwo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int MUL_STEPS    = 32;
  localparam int MUL_W        = 86;
  localparam int DIV_STEPS    = 86;
  localparam int DIVISOR_W    = 48;
  localparam int CFG_IDX_W    = 2;

  localparam logic [31:0] KINV_Q32          = 32'd2608131496;
  localparam logic [31:0] USEC_PER_SEC      = 32'd1000000;
  localparam logic [31:0] LINEAR_SCALE_RST  = 32'd674652;
  localparam logic [31:0] TURN_SCALE_RST    = 32'd306783;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINEAR_SCALE = 2'd0,
    CFG_TURN_SCALE   = 2'd1
  } mwo_cfg_e;

  typedef struct packed {
    logic signed [31:0] count_left_front;
    logic signed [31:0] count_right_front;
    logic signed [31:0] count_left_rear;
    logic signed [31:0] count_right_rear;
    logic        [31:0] stamp_us;
  } mwo_in_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic        [31:0] heading;
    logic signed [31:0] vel_forward;
    logic signed [31:0] vel_sideways;
    logic signed [31:0] vel_turn;
    logic               zero_interval;
  } mwo_out_t;

  // arctangent of 2^-i as binary angle, truncated
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

/* rtl/mwo_sermul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on mwo_pkg.
module mwo_sermul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mwo_pkg::MUL_W-1:0]   mcand_i,
  input  logic [31:0]                 mplier_i,
  output logic                        done_o,
  output logic [mwo_pkg::MUL_W-1:0]   prod_o
);

  logic                        busy_q, done_q;
  logic [4:0]                  cnt_q;
  logic [mwo_pkg::MUL_W-1:0]   acc_q, mc_q;
  logic [31:0]                 mp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(mwo_pkg::MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      acc_q <= '0;
      mc_q  <= mcand_i;
      mp_q  <= mplier_i;
    end else if (busy_q) begin
      if (mp_q[0]) acc_q <= acc_q + mc_q;
      mc_q <= {mc_q[mwo_pkg::MUL_W-2:0], 1'b0};
      mp_q <= {1'b0, mp_q[31:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* rtl/mwo_serdiv.sv */
// Restoring divider, one quotient bit per cycle; big_o flags a quotient of 2^31 or more.
// Depends on mwo_pkg.
module mwo_serdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mwo_pkg::MUL_W-1:0]     dividend_i,
  input  logic [mwo_pkg::DIVISOR_W-1:0] divisor_i,
  output logic                          done_o,
  output logic                          big_o,
  output logic [31:0]                   quot_o
);

  logic                           busy_q, done_q, ovf_q;
  logic [6:0]                     cnt_q;
  logic [mwo_pkg::MUL_W-1:0]      dvd_q;
  logic [mwo_pkg::DIVISOR_W-1:0]  dvs_q, rem_q;
  logic [32:0]                    quo_q;
  logic [mwo_pkg::DIVISOR_W:0]    rem_sh, rem_sub;
  logic                           qbit;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[mwo_pkg::MUL_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    qbit    = !rem_sub[mwo_pkg::DIVISOR_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'(mwo_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[mwo_pkg::MUL_W-2:0], 1'b0};
      rem_q <= qbit ? rem_sub[mwo_pkg::DIVISOR_W-1:0] : rem_sh[mwo_pkg::DIVISOR_W-1:0];
      quo_q <= {quo_q[31:0], qbit};
      // sticky overflow once quotient leaves 33 bits
      ovf_q <= ovf_q | quo_q[32];
    end
  end

  assign done_o = done_q;
  assign big_o  = ovf_q | quo_q[32] | quo_q[31];
  assign quot_o = quo_q[31:0];

endmodule

/* rtl/mecanum_wheel_odometry.sv */
// Mecanum wheel odometry top level: control sequencer, CORDIC rotator, accumulators.
// Depends on mwo_pkg, mwo_sermul, mwo_serdiv.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/in_stall_o   | mwo_in_t
//  out     | output    | out_valid_o/out_stall_i | mwo_out_t
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// The first item after reset only primes the stored counts and stamp and gives no result.
// Later items run three scale products, the CORDIC rotation and two gain products on
// the shared serial units, plus a velocity multiply and divide for each of the three
// velocities when the time delta is not zero.
// Reset clears the scales to defaults, position and heading to zero.
// A waiting result holds only the final write; a new item waits for the idle state.
module mecanum_wheel_odometry (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  mwo_pkg::mwo_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output mwo_pkg::mwo_out_t                  out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SUM  = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_POST = 9'b000001000,
    S_CORD = 9'b000010000,
    S_GAIN = 9'b000100000,
    S_VMUL = 9'b001000000,
    S_VDIV = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]        lin_scale_q, turn_scale_q;
  logic               primed_q;
  logic [31:0]        prev_cnt_q [4];
  logic [31:0]        prev_stamp_q;
  logic [31:0]        delta_q [4];
  logic [31:0]        dt_q;
  logic signed [33:0] sum_q [3];
  logic signed [33:0] sum_new [3];
  logic [65:0]        pm_q [3];
  logic [1:0]         k_q;
  logic [47:0]        acc_x_q, acc_y_q;
  logic [31:0]        head_q;
  logic signed [51:0] x_q, y_q;
  logic signed [33:0] z_q;
  logic [5:0]         cnt_q;
  logic [31:0]        vel_q [3];
  logic               out_valid_q;
  mwo_pkg::mwo_out_t  out_q;

  // serial unit hookup
  logic                          mul_start, mul_done;
  logic [mwo_pkg::MUL_W-1:0]     mul_mcand, mul_prod;
  logic [31:0]                   mul_mplier;
  logic                          div_start, div_done, div_big;
  logic [31:0]                   div_quot;

  logic               in_fire, out_fire;
  logic [31:0]        head_new;
  logic [31:0]        turn_lo;
  logic signed [47:0] dx, dy;
  logic               flip;
  logic [31:0]        ang;
  logic [4:0]         sh;
  logic signed [51:0] xs, ys;
  logic signed [33:0] at;
  logic [51:0]        gmag, gres;
  logic               gneg;
  logic [47:0]        gadd;
  logic [31:0]        vel_new;

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  // floor(signed sum * scale / 2^8), saturated to 48 bits
  function automatic logic signed [47:0] lin_inc(input logic [65:0] p, input logic neg);
    logic signed [59:0] v;
    logic [59:0]        q;
    q = {2'b00, p[65:8]};
    v = neg ? 60'(-q - {59'd0, |p[7:0]}) : q;
    if (v[59:47] == '0 || v[59:47] == '1) return v[47:0];
    return v[59] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
  endfunction

  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    sum_new[0] = 34'(signed'(delta_q[0])) + 34'(signed'(delta_q[1]))
               + 34'(signed'(delta_q[2])) + 34'(signed'(delta_q[3]));
    sum_new[1] = 34'(signed'(delta_q[1])) + 34'(signed'(delta_q[2]))
               - 34'(signed'(delta_q[0])) - 34'(signed'(delta_q[3]));
    sum_new[2] = 34'(signed'(delta_q[1])) + 34'(signed'(delta_q[3]))
               - 34'(signed'(delta_q[0])) - 34'(signed'(delta_q[2]));
  end

  assign turn_lo  = sum_q[2][33] ? 32'(-pm_q[2][31:0]) : pm_q[2][31:0];
  assign head_new = head_q + turn_lo;
  assign dx       = lin_inc(pm_q[0], sum_q[0][33]);
  assign dy       = lin_inc(pm_q[1], sum_q[1][33]);
  assign flip     = head_new[30] ^ head_new[31];
  assign ang      = flip ? {~head_new[31], head_new[30:0]} : head_new;

  assign sh = cnt_q[4:0];
  assign xs = x_q >>> sh;
  assign ys = y_q >>> sh;
  assign at = {2'b00, mwo_pkg::atan_lut(sh)};

  assign gneg = (k_q == 2'd0) ? x_q[51] : y_q[51];
  assign gmag = (k_q == 2'd0) ? (x_q[51] ? 52'(-x_q) : 52'(x_q))
                              : (y_q[51] ? 52'(-y_q) : 52'(y_q));
  assign gres = mul_prod[83:32];
  assign gadd = gneg ? 48'(-gres) : gres[47:0];

  always_comb begin
    if (sum_q[k_q][33]) vel_new = div_big ? 32'h80000000 : 32'(-div_quot);
    else                vel_new = div_big ? 32'h7FFFFFFF : div_quot;
  end

  // start pulses and operands for the shared serial units
  always_comb begin
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    div_start  = 1'b0;
    case (state_q)
      S_SUM: begin
        mul_start  = 1'b1;
        mul_mcand  = {52'd0, mag34(sum_new[0])};
        mul_mplier = lin_scale_q;
      end
      S_MUL: begin
        mul_start  = mul_done && (k_q != 2'd2);
        mul_mcand  = {52'd0, mag34(sum_q[k_q + 2'd1])};
        mul_mplier = (k_q == 2'd1) ? turn_scale_q : lin_scale_q;
      end
      S_CORD: begin
        // gain product for x starts once the rotation is done
        mul_start  = (cnt_q == 6'(mwo_pkg::CORDIC_STEPS));
        mul_mcand  = {34'd0, gmag};
        mul_mplier = mwo_pkg::KINV_Q32;
      end
      S_GAIN: begin
        mul_start  = mul_done && ((k_q == 2'd0) || (dt_q != '0));
        mul_mcand  = (k_q == 2'd0) ? {34'd0, (y_q[51] ? 52'(-y_q) : 52'(y_q))}
                                   : {20'd0, pm_q[0]};
        mul_mplier = (k_q == 2'd0) ? mwo_pkg::KINV_Q32 : mwo_pkg::USEC_PER_SEC;
      end
      S_VMUL: begin
        div_start = mul_done;
      end
      S_VDIV: begin
        mul_start  = div_done && (k_q != 2'd2);
        mul_mcand  = {20'd0, pm_q[k_q + 2'd1]};
        mul_mplier = mwo_pkg::USEC_PER_SEC;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire && primed_q) state_d = S_SUM;
      S_SUM:  state_d = S_MUL;
      S_MUL:  if (mul_done && k_q == 2'd2) state_d = S_POST;
      S_POST: state_d = S_CORD;
      S_CORD: if (cnt_q == 6'(mwo_pkg::CORDIC_STEPS)) state_d = S_GAIN;
      S_GAIN: begin
        if (mul_done && k_q == 2'd1) state_d = (dt_q == '0) ? S_OUT : S_VMUL;
      end
      S_VMUL: if (mul_done) state_d = S_VDIV;
      S_VDIV: begin
        if (div_done) state_d = (k_q == 2'd2) ? S_OUT : S_VMUL;
      end
      S_OUT:  if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      primed_q     <= 1'b0;
      lin_scale_q  <= mwo_pkg::LINEAR_SCALE_RST;
      turn_scale_q <= mwo_pkg::TURN_SCALE_RST;
      acc_x_q      <= '0;
      acc_y_q      <= '0;
      head_q       <= '0;
      out_valid_q  <= 1'b0;
      k_q          <= '0;
      cnt_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (mwo_pkg::mwo_cfg_e'(cfg_index_i))
          mwo_pkg::CFG_LINEAR_SCALE: lin_scale_q  <= cfg_data_i;
          mwo_pkg::CFG_TURN_SCALE:   turn_scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) primed_q <= 1'b1;
      if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
      case (state_q)
        S_SUM: k_q <= '0;
        S_MUL: if (mul_done) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        S_POST: begin
          head_q <= head_new;
          cnt_q  <= '0;
        end
        S_CORD: begin
          cnt_q <= cnt_q + 6'd1;
          k_q   <= '0;
        end
        S_GAIN: begin
          if (mul_done) begin
            if (k_q == 2'd0) begin
              acc_x_q <= acc_x_q + gadd;
              k_q     <= 2'd1;
            end else begin
              acc_y_q <= acc_y_q + gadd;
              k_q     <= 2'd0;
            end
          end
        end
        S_VDIV: if (div_done) k_q <= k_q + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prev_cnt_q[0] <= in_data_i.count_left_front;
      prev_cnt_q[1] <= in_data_i.count_right_front;
      prev_cnt_q[2] <= in_data_i.count_left_rear;
      prev_cnt_q[3] <= in_data_i.count_right_rear;
      prev_stamp_q  <= in_data_i.stamp_us;
      delta_q[0] <= in_data_i.count_left_front - prev_cnt_q[0];
      delta_q[1] <= in_data_i.count_right_front - prev_cnt_q[1];
      delta_q[2] <= in_data_i.count_left_rear - prev_cnt_q[2];
      delta_q[3] <= in_data_i.count_right_rear - prev_cnt_q[3];
      dt_q       <= in_data_i.stamp_us - prev_stamp_q;
    end
    case (state_q)
      S_SUM: begin
        sum_q[0] <= sum_new[0];
        sum_q[1] <= sum_new[1];
        sum_q[2] <= sum_new[2];
      end
      S_MUL: if (mul_done) pm_q[k_q] <= mul_prod[65:0];
      S_POST: begin
        // fold the angle into the right half plane
        x_q <= flip ? -52'(dx) : 52'(dx);
        y_q <= flip ? -52'(dy) : 52'(dy);
        z_q <= 34'(signed'(ang));
      end
      S_CORD: begin
        if (cnt_q < 6'(mwo_pkg::CORDIC_STEPS)) begin
          if (!z_q[33]) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - at;
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + at;
          end
        end
      end
      S_GAIN: begin
        if (mul_done && k_q == 2'd1) begin
          vel_q[0] <= '0;
          vel_q[1] <= '0;
          vel_q[2] <= '0;
        end
      end
      S_VDIV: if (div_done) vel_q[k_q] <= vel_new;
      default: ;
    endcase
    if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
      out_q.pos_x         <= acc_x_q;
      out_q.pos_y         <= acc_y_q;
      out_q.heading       <= head_q;
      out_q.vel_forward   <= vel_q[0];
      out_q.vel_sideways  <= vel_q[1];
      out_q.vel_turn      <= vel_q[2];
      out_q.zero_interval <= (dt_q == '0);
    end
  end

  mwo_sermul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  mwo_serdiv u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_prod),
    .divisor_i  ({dt_q, 16'd0}),
    .done_o     (div_done),
    .big_o      (div_big),
    .quot_o     (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/mwo_checker.sv */
// Port-level checks for the mecanum wheel odometry block, bound to the top level.
// Depends on mwo_pkg and mecanum_wheel_odometry.
module mwo_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input mwo_pkg::mwo_out_t out_data_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // a new result only comes out of a busy period
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in flight");

  // zero interval forces zero velocities
  a_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_interval |->
      out_data_o.vel_forward == '0 && out_data_o.vel_sideways == '0 &&
      out_data_o.vel_turn == '0)
    else $error("nonzero velocity on zero interval");

  // a result that appears during a busy period follows a stalled input side
  a_busy_no_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_valid_o |=> !out_valid_o || $past(in_stall_o))
    else $error("result without busy state");

endmodule

bind mecanum_wheel_odometry mwo_checker u_mwo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
